@@ rtl/lutc_pkg.sv @@
// Shared types, constants and tables for the local time to UTC calendar block.
// Used by lutc_alu, lutc_year_unit and the top level; no dependencies.
package lutc_pkg;

  localparam int EPOCH_YEAR   = 1970;
  localparam int LAST_YEAR    = 2099;
  localparam int YEAR_W       = $clog2(LAST_YEAR + 2);
  localparam int CEN_W        = $clog2(LAST_YEAR / 100 + 2);
  localparam int ACC_W        = 20;
  localparam int RECIP_100    = 5243;
  localparam int RECIP_SHIFT  = 19;
  localparam int RECIP_W      = 13;
  localparam int LAST_MONTH   = 12;
  localparam int MONTH_SAT    = 13;

  localparam logic signed [ACC_W-1:0] SECS_PER_DAY  = ACC_W'(86400);
  localparam logic signed [ACC_W-1:0] SECS_PER_HOUR = ACC_W'(3600);
  localparam logic signed [ACC_W-1:0] SECS_PER_MIN  = ACC_W'(60);
  localparam logic signed [11:0]      ZONE_UNSPEC   = 12'sd2047;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CENT,
    S_ZONE,
    S_HOUR,
    S_MIN,
    S_SEC,
    S_DBEF,
    S_SNEG,
    S_SDEC,
    S_SPOS,
    S_SINC,
    S_YBACK,
    S_YADD,
    S_YFWD,
    S_YINC,
    S_MON,
    S_HRS,
    S_MINS
  } state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic load;
    logic split;
    logic inc;
    logic dec;
  } yr_ctl_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic              at_epoch;
  } yr_stat_t;

  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = leap ? 9'd60  : 9'd59;
      4'd4:       d = leap ? 9'd91  : 9'd90;
      4'd5:       d = leap ? 9'd121 : 9'd120;
      4'd6:       d = leap ? 9'd152 : 9'd151;
      4'd7:       d = leap ? 9'd182 : 9'd181;
      4'd8:       d = leap ? 9'd213 : 9'd212;
      4'd9:       d = leap ? 9'd244 : 9'd243;
      4'd10:      d = leap ? 9'd274 : 9'd273;
      4'd11:      d = leap ? 9'd305 : 9'd304;
      4'd12:      d = leap ? 9'd335 : 9'd334;
      default:    d = leap ? 9'd366 : 9'd365;
    endcase
    return d;
  endfunction

  function automatic logic signed [ACC_W-1:0] year_days(input logic leap);
    return leap ? ACC_W'(366) : ACC_W'(365);
  endfunction

endpackage

@@ rtl/lutc_alu.sv @@
// Shared add/subtract unit for the local time to UTC calendar block.
// Depends on lutc_pkg.
module lutc_alu (
  input  lutc_pkg::alu_req_t                req,
  output logic signed [lutc_pkg::ACC_W-1:0] sum,
  output logic                              neg
);

  always_comb begin
    if (req.sub) begin
      sum = req.a - req.b;
    end else begin
      sum = req.a + req.b;
    end
    neg = sum[lutc_pkg::ACC_W-1];
  end

endmodule

@@ rtl/lutc_year_unit.sv @@
// Year counter with running year mod 100 and century, giving the leap and at-epoch flags.
// Depends on lutc_pkg.
module lutc_year_unit (
  input  logic                 clk,
  input  logic [11:0]          year_in,
  input  lutc_pkg::yr_ctl_t    ctl,
  output lutc_pkg::yr_stat_t   stat
);

  logic [lutc_pkg::YEAR_W-1:0]                    year_r;
  logic [lutc_pkg::CEN_W-1:0]                     cen_r;
  logic [6:0]                                     r100_r;
  logic [lutc_pkg::YEAR_W-1:0]                    year_clamp;
  logic [lutc_pkg::YEAR_W+lutc_pkg::RECIP_W-1:0]  prod;
  logic [6:0]                                     cen_x100;

  always_comb begin
    if (int'(year_in) < lutc_pkg::EPOCH_YEAR) begin
      year_clamp = lutc_pkg::YEAR_W'(lutc_pkg::EPOCH_YEAR);
    end else if (int'(year_in) > lutc_pkg::LAST_YEAR) begin
      year_clamp = lutc_pkg::YEAR_W'(lutc_pkg::LAST_YEAR);
    end else begin
      year_clamp = lutc_pkg::YEAR_W'(year_in);
    end
    prod = (lutc_pkg::YEAR_W+lutc_pkg::RECIP_W)'(year_clamp) *
           (lutc_pkg::YEAR_W+lutc_pkg::RECIP_W)'(lutc_pkg::RECIP_100);
    cen_x100 = 7'((7'(cen_r) << 6) + (7'(cen_r) << 5) + (7'(cen_r) << 2));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      year_r <= year_clamp;
      cen_r  <= lutc_pkg::CEN_W'(prod >> lutc_pkg::RECIP_SHIFT);
    end else if (ctl.split) begin
      r100_r <= 7'(year_r) - cen_x100;
    end else if (ctl.inc) begin
      year_r <= year_r + 1'b1;
      if (r100_r == 7'd99) begin
        r100_r <= '0;
        cen_r  <= cen_r + 1'b1;
      end else begin
        r100_r <= r100_r + 7'd1;
      end
    end else if (ctl.dec) begin
      year_r <= year_r - 1'b1;
      if (r100_r == 7'd0) begin
        r100_r <= 7'd99;
        cen_r  <= cen_r - 1'b1;
      end else begin
        r100_r <= r100_r - 7'd1;
      end
    end
  end

  always_comb begin
    stat.year     = year_r;
    stat.leap     = (year_r[1:0] == 2'b00) && ((r100_r != 7'd0) || (cen_r[1:0] == 2'b00));
    stat.at_epoch = (year_r == lutc_pkg::YEAR_W'(lutc_pkg::EPOCH_YEAR));
  end

endmodule

@@ rtl/local_time_to_utc_calendar_top.sv @@
// Top level: sequencer and registers of the local time to UTC calendar converter.
// Depends on lutc_pkg, lutc_alu and lutc_year_unit.
//
// A time stamp is taken when start is high and busy is low; busy then stays high until
// the result is shown. The result appears for one cycle with out_valid and cannot be held
// off, so the receiver must take it in that cycle. While busy, the block splits the year;
// then the single shared adder sums the second offsets, makes up to two day carries, one
// year step and up to 12 month compares, then one subtraction per hour and per minute of the
// result plus one to close each loop. The result shows in the first cycle with busy low, and
// a new time stamp is accepted in that cycle.
module local_time_to_utc_calendar_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        in_local_year,
  input  logic [3:0]         in_local_month,
  input  logic [4:0]         in_local_day,
  input  logic [4:0]         in_local_hour,
  input  logic [5:0]         in_local_minute,
  input  logic [5:0]         in_local_second,
  input  logic signed [11:0] in_zone_offset,
  output logic               out_valid,
  output logic [11:0]        out_utc_year,
  output logic [3:0]         out_utc_month,
  output logic [4:0]         out_utc_day,
  output logic [4:0]         out_utc_hour,
  output logic [5:0]         out_utc_minute,
  output logic [5:0]         out_utc_second,
  output logic               out_clamped
);

  localparam int AW = lutc_pkg::ACC_W;

  lutc_pkg::state_t   state_r, state_nxt;
  lutc_pkg::alu_req_t alu_req;
  lutc_pkg::yr_ctl_t  yctl;
  lutc_pkg::yr_stat_t ystat;

  logic signed [AW-1:0] alu_sum;
  logic                 alu_neg;
  logic                 in_xfer;

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] day_r, day_nxt;
  logic [3:0]           mon_r, mon_nxt;
  logic [4:0]           hr_r, hr_nxt;
  logic [5:0]           mn_r, mn_nxt;
  logic                 clamp_r, clamp_nxt;

  logic [3:0]           l_month_r;
  logic [4:0]           l_dm1_r;
  logic [4:0]           l_hour_r;
  logic [5:0]           l_minute_r;
  logic [5:0]           l_second_r;
  logic signed [11:0]   l_zone_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [11:0]          out_year_r;
  logic [3:0]           out_month_r;
  logic [4:0]           out_day_r;
  logic [4:0]           out_hour_r;
  logic [5:0]           out_minute_r;
  logic [5:0]           out_second_r;
  logic                 out_clamped_r;

  logic signed [AW-1:0] zone_ext, hour_ext, min_ext;
  logic signed [AW-1:0] zone_term, hour_term, min_term, sec_term;
  logic signed [AW-1:0] dbef_in, dbef_cur, ydays;

  lutc_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  lutc_year_unit u_year (
    .clk     (clk),
    .year_in (in_local_year),
    .ctl     (yctl),
    .stat    (ystat)
  );

  assign in_xfer = start && !busy;
  assign busy    = (state_r != lutc_pkg::S_IDLE);

  always_comb begin
    zone_ext  = AW'(l_zone_r);
    hour_ext  = $signed(AW'(l_hour_r));
    min_ext   = $signed(AW'(l_minute_r));
    zone_term = (l_zone_r == lutc_pkg::ZONE_UNSPEC) ? '0 : (zone_ext <<< 6) - (zone_ext <<< 2);
    hour_term = (hour_ext <<< 12) - (hour_ext <<< 9) + (hour_ext <<< 4);
    min_term  = (min_ext <<< 6) - (min_ext <<< 2);
    sec_term  = $signed(AW'(l_second_r));
    dbef_in   = $signed(AW'(lutc_pkg::days_before(ystat.leap, l_month_r)));
    dbef_cur  = $signed(AW'(lutc_pkg::days_before(ystat.leap, mon_r)));
    ydays     = lutc_pkg::year_days(ystat.leap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lutc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    day_r   <= day_nxt;
    mon_r   <= mon_nxt;
    hr_r    <= hr_nxt;
    mn_r    <= mn_nxt;
    clamp_r <= clamp_nxt;
    if (in_xfer) begin
      l_month_r  <= (in_local_month > 4'(lutc_pkg::MONTH_SAT)) ?
                    4'(lutc_pkg::MONTH_SAT) : in_local_month;
      l_dm1_r    <= (in_local_day == 5'd0) ? 5'd0 : in_local_day - 5'd1;
      l_hour_r   <= in_local_hour;
      l_minute_r <= in_local_minute;
      l_second_r <= in_local_second;
      l_zone_r   <= in_zone_offset;
    end
    if (out_load) begin
      out_year_r    <= 12'(ystat.year);
      out_month_r   <= mon_r;
      out_day_r     <= 5'(day_r + AW'(1));
      out_hour_r    <= hr_r;
      out_minute_r  <= mn_r;
      out_second_r  <= acc_r[5:0];
      out_clamped_r <= clamp_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    hr_nxt        = hr_r;
    mn_nxt        = mn_r;
    clamp_nxt     = clamp_r;
    out_valid_nxt = 1'b0;
    out_load      = 1'b0;
    yctl          = '0;
    alu_req.a     = acc_r;
    alu_req.b     = '0;
    alu_req.sub   = 1'b0;
    case (state_r)
      lutc_pkg::S_IDLE: begin
        if (in_xfer) begin
          yctl.load = 1'b1;
          clamp_nxt = 1'b0;
          state_nxt = lutc_pkg::S_CENT;
        end
      end
      lutc_pkg::S_CENT: begin
        yctl.split = 1'b1;
        state_nxt  = lutc_pkg::S_ZONE;
      end
      lutc_pkg::S_ZONE: begin
        alu_req.a = '0;
        alu_req.b = zone_term;
        acc_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_HOUR;
      end
      lutc_pkg::S_HOUR: begin
        alu_req.b = hour_term;
        acc_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_MIN;
      end
      lutc_pkg::S_MIN: begin
        alu_req.b = min_term;
        acc_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_SEC;
      end
      lutc_pkg::S_SEC: begin
        alu_req.b = sec_term;
        acc_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_DBEF;
      end
      lutc_pkg::S_DBEF: begin
        alu_req.a = dbef_in;
        alu_req.b = $signed(AW'(l_dm1_r));
        day_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_SNEG;
      end
      lutc_pkg::S_SNEG: begin
        alu_req.b = lutc_pkg::SECS_PER_DAY;
        if (acc_r[AW-1]) begin
          acc_nxt   = alu_sum;
          state_nxt = lutc_pkg::S_SDEC;
        end else begin
          state_nxt = lutc_pkg::S_SPOS;
        end
      end
      lutc_pkg::S_SDEC: begin
        alu_req.a   = day_r;
        alu_req.b   = AW'(1);
        alu_req.sub = 1'b1;
        day_nxt     = alu_sum;
        state_nxt   = lutc_pkg::S_SNEG;
      end
      lutc_pkg::S_SPOS: begin
        alu_req.b   = lutc_pkg::SECS_PER_DAY;
        alu_req.sub = 1'b1;
        if (!alu_neg) begin
          acc_nxt   = alu_sum;
          state_nxt = lutc_pkg::S_SINC;
        end else begin
          state_nxt = lutc_pkg::S_YBACK;
        end
      end
      lutc_pkg::S_SINC: begin
        alu_req.a = day_r;
        alu_req.b = AW'(1);
        day_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_SPOS;
      end
      lutc_pkg::S_YBACK: begin
        if (day_r[AW-1]) begin
          if (ystat.at_epoch) begin
            clamp_nxt = 1'b1;
            acc_nxt   = '0;
            day_nxt   = '0;
            state_nxt = lutc_pkg::S_YFWD;
          end else begin
            yctl.dec  = 1'b1;
            state_nxt = lutc_pkg::S_YADD;
          end
        end else begin
          state_nxt = lutc_pkg::S_YFWD;
        end
      end
      lutc_pkg::S_YADD: begin
        alu_req.a = day_r;
        alu_req.b = ydays;
        day_nxt   = alu_sum;
        state_nxt = lutc_pkg::S_YBACK;
      end
      lutc_pkg::S_YFWD: begin
        alu_req.a   = day_r;
        alu_req.b   = ydays;
        alu_req.sub = 1'b1;
        if (!alu_neg) begin
          day_nxt   = alu_sum;
          state_nxt = lutc_pkg::S_YINC;
        end else begin
          mon_nxt   = 4'(lutc_pkg::LAST_MONTH);
          state_nxt = lutc_pkg::S_MON;
        end
      end
      lutc_pkg::S_YINC: begin
        yctl.inc  = 1'b1;
        state_nxt = lutc_pkg::S_YFWD;
      end
      lutc_pkg::S_MON: begin
        alu_req.a   = day_r;
        alu_req.b   = dbef_cur;
        alu_req.sub = 1'b1;
        if (!alu_neg) begin
          day_nxt   = alu_sum;
          hr_nxt    = '0;
          state_nxt = lutc_pkg::S_HRS;
        end else begin
          mon_nxt = mon_r - 4'd1;
        end
      end
      lutc_pkg::S_HRS: begin
        alu_req.b   = lutc_pkg::SECS_PER_HOUR;
        alu_req.sub = 1'b1;
        if (!alu_neg) begin
          acc_nxt = alu_sum;
          hr_nxt  = hr_r + 5'd1;
        end else begin
          mn_nxt    = '0;
          state_nxt = lutc_pkg::S_MINS;
        end
      end
      lutc_pkg::S_MINS: begin
        alu_req.b   = lutc_pkg::SECS_PER_MIN;
        alu_req.sub = 1'b1;
        if (!alu_neg) begin
          acc_nxt = alu_sum;
          mn_nxt  = mn_r + 6'd1;
        end else begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lutc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lutc_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_utc_year   = out_year_r;
  assign out_utc_month  = out_month_r;
  assign out_utc_day    = out_day_r;
  assign out_utc_hour   = out_hour_r;
  assign out_utc_minute = out_minute_r;
  assign out_utc_second = out_second_r;
  assign out_clamped    = out_clamped_r;

endmodule

@@ rtl/lutc_checker.sv @@
// Port-level checks for the local time to UTC calendar block, bound to the top level.
// Depends on local_time_to_utc_calendar_top.
module lutc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [11:0] out_utc_year,
  input logic [3:0]  out_utc_month,
  input logic [4:0]  out_utc_day,
  input logic [4:0]  out_utc_hour,
  input logic [5:0]  out_utc_minute,
  input logic [5:0]  out_utc_second,
  input logic        out_clamped
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transfer did not raise busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without finished transfer");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> out_utc_year == 12'd1970 && out_utc_month == 4'd1 &&
      out_utc_day == 5'd1 && out_utc_hour == 5'd0 && out_utc_minute == 6'd0 &&
      out_utc_second == 6'd0)
    else $error("clamped result is not the epoch");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_utc_month >= 4'd1 && out_utc_month <= 4'd12 && out_utc_day >= 5'd1 &&
      out_utc_hour <= 5'd23 && out_utc_minute <= 6'd59 && out_utc_second <= 6'd59)
    else $error("result not normalized");

endmodule

bind local_time_to_utc_calendar_top lutc_checker u_lutc_checker (.*);
